// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers, clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error(msg);

// Implication checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
    else $error(msg);

`endif

// ----- hw/rtl/wmsm_pkg.sv -----
`default_nettype none

package wmsm_pkg;

  localparam int unsigned FIELD_W = 64;
  localparam int unsigned HALF_W  = 32;

  typedef enum logic [1:0] {
    ACT_UNSIGNED        = 2'd0,
    ACT_SIGNED          = 2'd1,
    ACT_SIGNED_UNSIGNED = 2'd2,
    ACT_UNSIGNED_ALT    = 2'd3
  } action_t;

  typedef logic [FIELD_W-1:0]   word_t;
  typedef logic [2*FIELD_W-1:0] dword_t;
  typedef logic [2*HALF_W-1:0]  pp_t;

endpackage

`default_nettype wire

// ----- hw/rtl/widening_multiplier_signed_modes.sv -----
`default_nettype none

// Widening multiplier: full 2*WIDTH-bit product of two WIDTH-bit operands.
// Request channel: in_action, in_operand_x, in_operand_y are taken at a rising
// edge with start high and busy low. busy is always low: a new request may be
// issued every cycle, independent of those still in flight.
// in_action selects unsigned*unsigned (0 or 3), signed*signed (1), or
// signed x * unsigned y (2). Operand bits above WIDTH are ignored.
// Result channel: out_product_high / out_product_low are valid for exactly one
// cycle while out_strobe is high, once the request has left the last stage, in
// request order. The receiver cannot stall; the pipeline never holds.
// Throughput is one request per cycle; the pipeline has five register
// stages: magnitude, four 32x32 partial products, low-word sum with carry,
// high-word sum, and conditional 128-bit negate with output formatting.
// Reset (synchronous, rst_n low) clears the stage valid bits, so requests in
// flight are dropped and out_strobe stays low until new requests arrive.
// Result bits at and above WIDTH in each output word read as zero.
module widening_multiplier_signed_modes
  import wmsm_pkg::*;
#(
  parameter int unsigned WIDTH = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [1:0]          in_action,
  input  wire logic [FIELD_W-1:0]  in_operand_x,
  input  wire logic [FIELD_W-1:0]  in_operand_y,
  output logic                     out_strobe,
  output logic [FIELD_W-1:0]       out_product_high,
  output logic [FIELD_W-1:0]       out_product_low
);

`include "assert_macros.svh"

  // mask of the live operand bits
  localparam word_t WMASK = {FIELD_W{1'b1}} >> (FIELD_W - WIDTH);

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // ---------------------------------------------------------------------------
  // Stage 1: sign decode and operand magnitudes
  // ---------------------------------------------------------------------------
  word_t x_m, y_m;
  logic  x_neg, y_neg;
  word_t mx_nxt, my_nxt;
  logic  neg1_nxt;
  word_t mx_r, my_r;
  logic  neg1_r, v1_r;

  always_comb begin
    x_m   = in_operand_x & WMASK;
    y_m   = in_operand_y & WMASK;
    x_neg = 1'b0;
    y_neg = 1'b0;
    case (action_t'(in_action))
      ACT_SIGNED: begin
        x_neg = x_m[WIDTH-1];
        y_neg = y_m[WIDTH-1];
      end
      ACT_SIGNED_UNSIGNED: begin
        x_neg = x_m[WIDTH-1];
      end
      default: begin
        x_neg = 1'b0;
        y_neg = 1'b0;
      end
    endcase
    mx_nxt   = x_neg ? ((~x_m + word_t'(1)) & WMASK) : x_m;
    my_nxt   = y_neg ? ((~y_m + word_t'(1)) & WMASK) : y_m;
    neg1_nxt = x_neg ^ y_neg;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: four half-width partial products
  // ---------------------------------------------------------------------------
  pp_t  p0_nxt, p1_nxt, p2_nxt, p3_nxt;
  pp_t  p0_r, p1_r, p2_r, p3_r;
  logic neg2_r, v2_r;

  always_comb begin
    p0_nxt = pp_t'(mx_r[HALF_W-1:0])       * pp_t'(my_r[HALF_W-1:0]);
    p1_nxt = pp_t'(mx_r[FIELD_W-1:HALF_W]) * pp_t'(my_r[HALF_W-1:0]);
    p2_nxt = pp_t'(mx_r[HALF_W-1:0])       * pp_t'(my_r[FIELD_W-1:HALF_W]);
    p3_nxt = pp_t'(mx_r[FIELD_W-1:HALF_W]) * pp_t'(my_r[FIELD_W-1:HALF_W]);
  end

  // ---------------------------------------------------------------------------
  // Stage 3: middle sum and low word with its carry out
  // ---------------------------------------------------------------------------
  logic [2*HALF_W:0]  mid;
  logic [FIELD_W:0]   lo_sum;
  word_t              lo_nxt;
  logic               cl_nxt;
  logic [HALF_W:0]    midhi_nxt;
  word_t              lo_r;
  logic               cl_r;
  logic [HALF_W:0]    midhi_r;
  pp_t                p3_3_r;
  logic               neg3_r, v3_r;

  always_comb begin
    mid       = {1'b0, p1_r} + {1'b0, p2_r};
    lo_sum    = {1'b0, p0_r} + {1'b0, mid[HALF_W-1:0], {HALF_W{1'b0}}};
    lo_nxt    = lo_sum[FIELD_W-1:0];
    cl_nxt    = lo_sum[FIELD_W];
    midhi_nxt = mid[2*HALF_W:HALF_W];
  end

  // ---------------------------------------------------------------------------
  // Stage 4: high word
  // ---------------------------------------------------------------------------
  word_t  hi_nxt;
  dword_t prod4_r;
  logic   neg4_r, v4_r;

  assign hi_nxt = p3_3_r + word_t'(midhi_r) + word_t'(cl_r);

  // ---------------------------------------------------------------------------
  // Stage 5: sign fix-up and split at WIDTH
  // ---------------------------------------------------------------------------
  dword_t prod_fix, prod_sh;
  word_t  ph_nxt, pl_nxt;
  word_t  ph_r, pl_r;
  logic   v5_r;

  always_comb begin
    prod_fix = neg4_r ? (~prod4_r + dword_t'(1)) : prod4_r;
    prod_sh  = prod_fix >> WIDTH;
    pl_nxt   = prod_fix[FIELD_W-1:0] & WMASK;
    ph_nxt   = prod_sh[FIELD_W-1:0] & WMASK;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    mx_r    <= mx_nxt;
    my_r    <= my_nxt;
    neg1_r  <= neg1_nxt;
    p0_r    <= p0_nxt;
    p1_r    <= p1_nxt;
    p2_r    <= p2_nxt;
    p3_r    <= p3_nxt;
    neg2_r  <= neg1_r;
    lo_r    <= lo_nxt;
    cl_r    <= cl_nxt;
    midhi_r <= midhi_nxt;
    p3_3_r  <= p3_r;
    neg3_r  <= neg2_r;
    prod4_r <= {hi_nxt, lo_r};
    neg4_r  <= neg3_r;
    ph_r    <= ph_nxt;
    pl_r    <= pl_nxt;
  end

  assign out_strobe       = v5_r;
  assign out_product_high = ph_r;
  assign out_product_low  = pl_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `ASSERT_IMPL(a_strobe_has_request, out_strobe, $past(accept, 5),
               "result strobe without a request five cycles earlier")
  `ASSERT_IMPL(a_zero_operand, accept && ((in_operand_x & WMASK) == '0),
               ##5 (out_strobe && out_product_high == '0 && out_product_low == '0),
               "zero operand did not give a zero product")
  `ASSERT_IMPL(a_unit_multiplier,
               accept && (in_operand_y & WMASK) == word_t'(1) &&
               (in_action == ACT_UNSIGNED || in_action == ACT_UNSIGNED_ALT),
               ##5 (out_product_high == '0 &&
                    out_product_low == ($past(in_operand_x, 5) & WMASK)),
               "unsigned multiply by one did not return the operand")
  `ASSERT_IMPL(a_upper_bits_clear, out_strobe,
               ((out_product_high & ~WMASK) == '0 && (out_product_low & ~WMASK) == '0),
               "result bits above WIDTH are set")

endmodule

`default_nettype wire
